FILE: rtl/scr_pkg.sv
// Shared types and constants for the segmented cache replacement unit.
// It has no dependencies. The controller, the datapath and the top level import it.
`timescale 1ns / 1ps
`default_nettype none

package scr_pkg;

   // Default storage shape.
   localparam int SCR_CAPACITY  = 64;
   localparam int SCR_KEY_WIDTH = 32;

   // Size register: its width and its value after reset.
   localparam int          CSR_W     = 7;
   localparam logic [6:0]  CSR_RESET = 7'd64;

   // Constant division by five through a reciprocal: x / 5 == (x * 205) >> 10.
   // This holds for every x below 1024.
   localparam logic [15:0] DIV5_MUL   = 16'd205;
   localparam int          DIV5_SHIFT = 10;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic key_load;   // Capture the request key.
      logic rd_en;      // Read the key store.
      logic wr_en;      // Write the key store.
      logic wr_key;     // Write the request key rather than the data just read.
   } dp_cmd_type;

endpackage

`default_nettype wire

FILE: rtl/segmented_cache_replacement_unit.sv
// Segmented (in / out / hot) page cache replacement unit: the top level.
// Each entry searched passes through a read state and a compare state, each entry shifted
// through a read state and a write state, then come the key write and the result state;
// the pace is set by the single read port of the key store. One beat is in flight at a time.
// Reset: the size is 64 and all segment fills are zero. The key store is not cleared.
// It depends on scr_pkg, scr_controller and scr_datapath.
`timescale 1ns / 1ps
`default_nettype none

module segmented_cache_replacement_unit #(
   parameter int CAPACITY  = scr_pkg::SCR_CAPACITY,
   parameter int KEY_WIDTH = scr_pkg::SCR_KEY_WIDTH
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_valid,
   output logic                             req_ready,
   input  wire signed [KEY_WIDTH-1:0]       req_page_key,
   output logic                             rsp_valid,
   input  wire                              rsp_ready,
   output logic                             rsp_hit,
   input  wire                              csr_wr_en,
   input  wire [scr_pkg::CSR_W-1:0]         csr_wr_data
);
   import scr_pkg::*;

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

   dp_cmd_type      cmd;
   logic [AW-1:0]   rd_addr;
   logic [AW-1:0]   wr_addr;
   logic            match;

   scr_controller #(
      .CAPACITY (CAPACITY)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_hit     (rsp_hit),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .match       (match),
      .cmd         (cmd),
      .rd_addr     (rd_addr),
      .wr_addr     (wr_addr)
   );

   scr_datapath #(
      .CAPACITY  (CAPACITY),
      .KEY_WIDTH (KEY_WIDTH)
   ) u_dp (
      .clock        (clock),
      .req_page_key (req_page_key),
      .cmd          (cmd),
      .rd_addr      (rd_addr),
      .wr_addr      (wr_addr),
      .match        (match)
   );

   // Once a request beat is taken, the unit is busy on the next cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while the previous one is still in work");

   // A new response appears only when a lookup has just finished.
   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("response raised without a finished lookup");

   // The key store is never read and written in the same step.
   a_single_port_use: assert property (@(posedge clock) disable iff (reset)
      !(cmd.rd_en && cmd.wr_en))
      else $error("key store read and written in one cycle");

   // A key is captured only on an accepted request beat.
   a_key_load: assert property (@(posedge clock) disable iff (reset)
      cmd.key_load |-> (req_valid && req_ready))
      else $error("key captured without an accepted request");

endmodule

`default_nettype wire

FILE: rtl/scr_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// It has no dependencies.
`timescale 1ns / 1ps
`default_nettype none

module scr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire                                      clock,
   input  wire                                      wr_en,
   input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire [WIDTH-1:0]                          wr_data,
   input  wire                                      rd_en,
   input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // A write and a registered read can both happen in the same cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

FILE: rtl/scr_datapath.sv
// Datapath: the request key register, the key store RAM and the key comparator.
// It depends on scr_pkg and scr_ram.
`timescale 1ns / 1ps
`default_nettype none

module scr_datapath #(
   parameter int CAPACITY  = scr_pkg::SCR_CAPACITY,
   parameter int KEY_WIDTH = scr_pkg::SCR_KEY_WIDTH
) (
   input  wire                                               clock,
   input  wire signed [KEY_WIDTH-1:0]                        req_page_key,
   input  scr_pkg::dp_cmd_type                               cmd,
   input  wire [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] rd_addr,
   input  wire [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] wr_addr,
   output logic                                              match
);
   import scr_pkg::*;

   logic [KEY_WIDTH-1:0] key_ff;
   logic [KEY_WIDTH-1:0] key_in;
   logic [KEY_WIDTH-1:0] rd_data;
   logic [KEY_WIDTH-1:0] wr_data;

   // Keys are compared as raw bit patterns.
   assign key_in = cmd.key_load ? $unsigned(req_page_key) : key_ff;

   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

   // A shift step writes back the entry it just read. The final write stores the key.
   assign wr_data = cmd.wr_key ? key_ff : rd_data;
   assign match   = (rd_data == key_ff);

   scr_ram #(
      .WIDTH (KEY_WIDTH),
      .DEPTH (CAPACITY)
   ) u_key_store (
      .clock   (clock),
      .wr_en   (cmd.wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

endmodule

`default_nettype wire

FILE: rtl/scr_controller.sv
// Controller: the sequencer that searches and shifts, the segment fill counters,
// the size register and the response register. It depends on scr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module scr_controller #(
   parameter int CAPACITY = scr_pkg::SCR_CAPACITY
) (
   input  wire                                                clock,
   input  wire                                                reset,
   input  wire                                                req_valid,
   output logic                                               req_ready,
   output logic                                               rsp_valid,
   input  wire                                                rsp_ready,
   output logic                                               rsp_hit,
   input  wire                                                csr_wr_en,
   input  wire [scr_pkg::CSR_W-1:0]                           csr_wr_data,
   input  wire                                                match,
   output scr_pkg::dp_cmd_type                                cmd,
   output logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] rd_addr,
   output logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] wr_addr
);
   import scr_pkg::*;

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int PW = $clog2(CAPACITY + 1);

   typedef enum logic [2:0] {
      IDLE,
      SRCH_RD,
      SRCH_CMP,
      SH_RD,
      SH_WR,
      KEY_WR,
      DONE
   } state_type;

   state_type         state_ff, state_in;
   logic [CSR_W-1:0]  size_ff, size_in;
   logic [PW-1:0]     in_cnt_ff, in_cnt_in;
   logic [PW-1:0]     out_cnt_ff, out_cnt_in;
   logic [PW-1:0]     hot_cnt_ff, hot_cnt_in;
   logic [PW-1:0]     idx_ff, idx_in;
   logic [PW-1:0]     cur_ff, cur_in;
   logic [PW-1:0]     end_ff, end_in;
   logic              left_ff, left_in;
   logic              hit_ff, hit_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_hit_ff, rsp_hit_in;

   logic [PW-1:0]     eff;
   logic [15:0]       div_prod;
   logic [PW-1:0]     hot_size;
   logic [PW-1:0]     out_size;
   logic [PW-1:0]     in_size;
   logic [PW-1:0]     total;
   logic [PW-1:0]     in_out;
   logic [PW-1:0]     sh_src;
   logic [PW-1:0]     idx_next;
   logic              accept;
   logic              decide;
   logic              dec_hit;
   logic              do_key;

   // Segment sizes come from the size register, limited to the capacity.
   always_comb begin
      if (32'(size_ff) > CAPACITY) begin
         eff = PW'(CAPACITY);
      end else begin
         eff = PW'(size_ff);
      end
      div_prod = 16'(eff) * DIV5_MUL;
      hot_size = PW'(div_prod >> DIV5_SHIFT);
      out_size = PW'(hot_size * 2'd3);
      in_size  = eff - out_size - hot_size;
   end

   assign total    = in_cnt_ff + out_cnt_ff + hot_cnt_ff;
   assign in_out   = in_cnt_ff + out_cnt_ff;
   assign accept   = req_valid && req_ready;
   assign idx_next = idx_ff + 1'b1;
   assign sh_src   = left_ff ? (cur_ff + 1'b1) : (cur_ff - 1'b1);

   // A decision is made when a match is found, when the search runs out, or at once
   // when the cache is empty.
   assign dec_hit = (state_ff == SRCH_CMP) && match;
   assign decide  = ((state_ff == IDLE) && accept && (total == '0)) ||
                    ((state_ff == SRCH_CMP) && (match || (idx_next == total)));

   // Next-state logic for the sequencer and all of its registers.
   always_comb begin
      state_in     = state_ff;
      size_in      = size_ff;
      in_cnt_in    = in_cnt_ff;
      out_cnt_in   = out_cnt_ff;
      hot_cnt_in   = hot_cnt_ff;
      idx_in       = idx_ff;
      cur_in       = cur_ff;
      end_in       = end_ff;
      left_in      = left_ff;
      hit_in       = hit_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_hit_in   = rsp_hit_ff;
      do_key       = 1'b0;

      // A size write also empties the cache.
      if (csr_wr_en) begin
         size_in    = csr_wr_data;
         in_cnt_in  = '0;
         out_cnt_in = '0;
         hot_cnt_in = '0;
      end

      unique case (state_ff)
         IDLE: begin
            if (accept) begin
               idx_in   = '0;
               state_in = SRCH_RD;
            end
         end
         SRCH_RD: begin
            state_in = SRCH_CMP;
         end
         SRCH_CMP: begin
            idx_in   = idx_next;
            state_in = SRCH_RD;
         end
         SH_RD: begin
            state_in = SH_WR;
         end
         SH_WR: begin
            cur_in = sh_src;
            if (left_ff ? (sh_src < end_ff) : (sh_src > end_ff)) begin
               state_in = SH_RD;
            end else begin
               state_in = KEY_WR;
            end
         end
         KEY_WR: begin
            state_in = DONE;
         end
         DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_hit_in   = hit_ff;
               state_in     = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase

      // Choose the shift range, where the key goes and the new fill counts.
      if (decide) begin
         hit_in  = dec_hit;
         left_in = 1'b0;
         end_in  = '0;
         cur_in  = total;
         if (!dec_hit) begin
            if (in_cnt_ff < in_size) begin
               in_cnt_in = in_cnt_ff + 1'b1;
               do_key    = 1'b1;
            end else if (out_cnt_ff < out_size) begin
               out_cnt_in = out_cnt_ff + 1'b1;
               do_key     = 1'b1;
            end else if ((in_size + out_size) != '0) begin
               // Both FIFOs are full: the oldest out key falls off the end.
               cur_in = in_size + out_size - 1'b1;
               do_key = 1'b1;
            end
         end else if (idx_ff >= in_out) begin
            // A hot hit moves the key to the most recent hot place.
            cur_in = idx_ff;
            end_in = in_out;
            do_key = 1'b1;
         end else if (idx_ff >= in_cnt_ff) begin
            // An out hit promotes the key. A full hot list loses its last entry.
            left_in    = 1'b1;
            cur_in     = idx_ff;
            end_in     = in_out - 1'b1;
            out_cnt_in = out_cnt_ff - 1'b1;
            do_key     = 1'b1;
            if (hot_cnt_ff < hot_size) begin
               hot_cnt_in = hot_cnt_ff + 1'b1;
            end
         end
         if (!do_key) begin
            state_in = DONE;
         end else if (left_in ? (cur_in < end_in) : (cur_in > end_in)) begin
            state_in = SH_RD;
         end else begin
            state_in = KEY_WR;
         end
      end
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         size_ff      <= CSR_RESET;
         in_cnt_ff    <= '0;
         out_cnt_ff   <= '0;
         hot_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         size_ff      <= size_in;
         in_cnt_ff    <= in_cnt_in;
         out_cnt_ff   <= out_cnt_in;
         hot_cnt_ff   <= hot_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff     <= idx_in;
      cur_ff     <= cur_in;
      end_ff     <= end_in;
      left_ff    <= left_in;
      hit_ff     <= hit_in;
      rsp_hit_ff <= rsp_hit_in;
   end

   // Drive the datapath commands and addresses from the current state.
   always_comb begin
      cmd.key_load = accept;
      cmd.rd_en    = (state_ff == SRCH_RD) || (state_ff == SH_RD);
      cmd.wr_en    = (state_ff == SH_WR) || (state_ff == KEY_WR);
      cmd.wr_key   = (state_ff == KEY_WR);
      rd_addr      = (state_ff == SH_RD) ? sh_src[AW-1:0] : idx_ff[AW-1:0];
      wr_addr      = (state_ff == KEY_WR) ? end_ff[AW-1:0] : cur_ff[AW-1:0];
   end

   assign req_ready = (state_ff == IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_hit   = rsp_hit_ff;

endmodule

`default_nettype wire

FILE: bench/scr_checker.sv
// Checker for the segmented cache replacement unit: watches request, response and
// size-register ports, predicts each hit flag and compares. Depends on scr_pkg.
`timescale 1ns / 1ps

module scr_checker (
   input  wire        clock,
   input  wire        reset,
   input  wire        req_valid,
   input  wire        req_ready,
   input  wire [31:0] req_page_key,
   input  wire        rsp_valid,
   input  wire        rsp_ready,
   input  wire        rsp_hit,
   input  wire        csr_wr_en,
   input  wire [scr_pkg::CSR_W-1:0] csr_wr_data,
   output int         fail_count,
   output int         pending_hits,
   output int         hit_total,
   output int         miss_total
);
   localparam int CAP = scr_pkg::SCR_CAPACITY;

   logic [31:0] resident [CAP];
   int          in_fill, out_fill, hot_fill;
   logic [6:0]  size_reg;
   bit          expected_hits [$];

   initial begin
      fail_count = 0;
      hit_total = 0;
      miss_total = 0;
   end

   assign pending_hits = expected_hits.size();

   // Remove the entry at pos from a list of n entries.
   function automatic void remove_at(input int pos, input int n);
      for (int i = pos; i < n - 1; i++) resident[i] = resident[i + 1];
   endfunction

   // Insert key at pos into a list of n entries.
   function automatic void insert_at(input int pos, input int n, input logic [31:0] key);
      if (pos > n || n >= CAP) return;
      for (int i = n; i > pos; i--) resident[i] = resident[i - 1];
      resident[pos] = key;
   endfunction

   // Update the segment lists for one key and return whether it was resident.
   function automatic bit lookup_page(input logic [31:0] key);
      int eff, hot_sz, out_sz, in_sz, total, found;
      eff = (size_reg > CAP) ? CAP : size_reg;
      hot_sz = eff / 5;
      out_sz = 3 * (eff / 5);
      in_sz = eff - out_sz - hot_sz;
      total = in_fill + out_fill + hot_fill;
      found = total;
      for (int i = 0; i < total; i++) begin
         if (resident[i] == key) begin
            found = i;
            break;
         end
      end
      if (found >= total) begin
         if (in_fill < in_sz) begin
            insert_at(0, total, key);
            in_fill++;
         end else if (out_fill < out_sz) begin
            insert_at(0, total, key);
            out_fill++;
         end else if (in_sz + out_sz > 0) begin
            remove_at(in_sz + out_sz - 1, total);
            insert_at(0, total - 1, key);
         end
         return 0;
      end
      if (found >= in_fill + out_fill) begin
         remove_at(found, total);
         insert_at(in_fill + out_fill, total - 1, key);
      end else if (found >= in_fill) begin
         remove_at(found, total);
         insert_at(in_fill + out_fill - 1, total - 1, key);
         out_fill--;
         if (hot_fill >= hot_sz) remove_at(total - 1, total);
         else hot_fill++;
      end
      return 1;
   endfunction

   task automatic report_mismatch(input string what);
      $display("scr_checker: mismatch at %0t: %s", $realtime, what);
      fail_count++;
   endtask

   // Follow the register, then the beats on each channel.
   always @(posedge clock) begin
      if (reset) begin
         size_reg <= scr_pkg::CSR_RESET;
         in_fill = 0;
         out_fill = 0;
         hot_fill = 0;
         expected_hits.delete();
      end else begin
         if (csr_wr_en) begin
            size_reg <= csr_wr_data;
            in_fill = 0;
            out_fill = 0;
            hot_fill = 0;
         end
         if (req_valid && req_ready) expected_hits.push_back(lookup_page(req_page_key));
         if (rsp_valid && rsp_ready) begin
            if (expected_hits.size() == 0) begin
               report_mismatch("response beat with nothing expected");
            end else begin
               bit want;
               want = expected_hits.pop_front();
               if (want) hit_total++;
               else miss_total++;
               if (rsp_hit !== want)
                  report_mismatch($sformatf("hit %b, expected %b", rsp_hit, want));
            end
         end
      end
   end
endmodule

FILE: bench/tb_top.sv
// Top of the testbench: clock, reset, stimulus and verdict for the cache replacement
// unit. Depends on scr_pkg, segmented_cache_replacement_unit and scr_checker.
`timescale 1ns / 1ps

module tb_top;
   localparam int STALL_LIMIT = 20000;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [31:0] req_page_key;
   logic        rsp_valid;
   logic        rsp_ready;
   logic        rsp_hit;
   logic        csr_wr_en;
   logic [scr_pkg::CSR_W-1:0] csr_wr_data;
   int          fail_count, pending_hits, hit_total, miss_total;
   int          idle_cycles;
   bit          long_hold;
   logic [31:0] key_pool [16];

   segmented_cache_replacement_unit uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_page_key(req_page_key),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_hit(rsp_hit),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   scr_checker chk (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_page_key(req_page_key),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_hit(rsp_hit),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .fail_count(fail_count), .pending_hits(pending_hits),
      .hit_total(hit_total), .miss_total(miss_total)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // Mostly short gaps, now and then a long one.
   function automatic int gap_length();
      if ($urandom_range(0, 2) == 0) return 0;
      if ($urandom_range(0, 15) == 0) return $urandom_range(10, 40);
      return $urandom_range(0, 3);
   endfunction

   // Receiver: random stalls, plus one long hold while the sender keeps offering.
   initial begin
      int stall;
      rsp_ready = 0;
      @(posedge clock iff !reset);
      forever begin
         if (long_hold) begin
            rsp_ready <= 0;
            repeat (300) @(posedge clock);
            long_hold = 0;
         end
         stall = gap_length();
         if (stall > 0) begin
            rsp_ready <= 0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1;
         @(posedge clock);
      end
   end

   // Watchdog: cycles with no beat on either channel.
   initial begin
      idle_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("tb_top: watchdog expired with %0d outstanding", pending_hits);
            $display("tb_top: done, errors");
            $finish;
         end
      end
   end

   // Offer one request beat and wait until it is taken. Valid stays high after the
   // beat so that a following beat can come back to back; a gap lowers it first.
   task automatic send_page(input logic [31:0] key, input bit with_gap);
      int g;
      g = with_gap ? gap_length() : 0;
      if (g > 0) begin
         req_valid <= 0;
         repeat (g) @(posedge clock);
      end
      req_valid <= 1;
      req_page_key <= key;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Write the size register once all responses are in and the unit has settled.
   task automatic write_size(input logic [6:0] value);
      req_valid <= 0;
      while (pending_hits != 0) @(posedge clock);
      repeat (4 * 64 + 8) @(posedge clock);
      csr_wr_en <= 1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 0;
   endtask

   // Keys drawn mostly from a small pool so that every segment sees hits.
   function automatic logic [31:0] pick_key(input int spread);
      if ($urandom_range(0, 9) == 0) return $urandom;
      return key_pool[$urandom_range(0, spread - 1)];
   endfunction

   initial begin
      logic [6:0] sizes [8];
      req_valid = 0;
      req_page_key = 0;
      csr_wr_en = 0;
      csr_wr_data = 0;
      long_hold = 0;
      sizes = '{7'd10, 7'd0, 7'd4, 7'd127, 7'd5, 7'd64, 7'd65, 7'd23};
      foreach (key_pool[i]) key_pool[i] = $urandom;
      key_pool[0] = 32'h8000_0000;
      key_pool[1] = 32'h7FFF_FFFF;
      key_pool[2] = 32'h0000_0000;
      key_pool[3] = 32'hFFFF_FFFF;
      reset = 1;
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: reset size, extreme keys, then walk one size-ten cache through
      // in-hit, spill into out, out-hit promotion and a full hot list that drops its last key.
      send_page(32'h8000_0000, 0);
      send_page(32'h7FFF_FFFF, 0);
      send_page(32'h8000_0000, 0);
      send_page(32'h0000_0000, 0);
      send_page(32'hFFFF_FFFF, 0);
      write_size(7'd10);
      for (int i = 0; i < 8; i++) send_page(32'h100 + i, 0);
      send_page(32'h107, 0);
      send_page(32'h100, 0);
      send_page(32'h101, 0);
      send_page(32'h102, 0);
      send_page(32'h100, 0);
      send_page(32'h100, 0);
      write_size(7'd0);
      send_page(32'h5, 0);
      send_page(32'h5, 0);

      // Random: several sizes, extremes included, with a long receiver hold.
      foreach (sizes[s]) begin
         write_size(sizes[s]);
         for (int n = 0; n < 110; n++) begin
            if (s == 3 && n == 20) long_hold = 1;
            send_page(pick_key((sizes[s] > 12) ? 16 : 8), 1);
         end
      end

      req_valid <= 0;
      while (pending_hits != 0) @(posedge clock);
      repeat (4 * 64 + 8) @(posedge clock);
      $display("tb_top: %0d hits and %0d misses checked over eight cache sizes (0 to 127).",
               hit_total, miss_total);
      if (fail_count == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end
endmodule

FILE: sim.f
rtl/scr_pkg.sv
rtl/scr_ram.sv
rtl/scr_datapath.sv
rtl/scr_controller.sv
rtl/segmented_cache_replacement_unit.sv
bench/scr_checker.sv
bench/tb_top.sv
